// ----- src/pidl_pkg.sv -----
// Shared types, register codes and constants for the positional PID block.
package pidl_pkg;

    // Default widths of the sample and the integral accumulator.
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int INTEGRAL_WIDTH_DEF = 32;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Output drive width.
    localparam int DRIVE_W = 16;

    // Scale factors applied to the integral term and to the drive sum.
    localparam int ITERM_SCALE = 1000;
    localparam int DRV_SCALE   = 100;

    // Division of the integral product by 1000. Operands below 2^25 are exact.
    localparam int                     DIV_I_XW    = 25;
    localparam int                     DIV_I_MW    = 26;
    localparam int                     DIV_I_SHIFT = 35;
    localparam logic [DIV_I_MW-1:0]    DIV_I_MUL   = 26'd34359739;

    // Division of the drive sum by 100. Operands below 2^22 are exact.
    localparam int                     DIV_D_XW    = 22;
    localparam int                     DIV_D_MW    = 23;
    localparam int                     DIV_D_SHIFT = 29;
    localparam logic [DIV_D_MW-1:0]    DIV_D_MUL   = 23'd5368710;

    // Quotient width after either division (magnitudes up to 32767).
    localparam int QUOT_W = 15;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_DEAD_BAND    = 3'd3,
        REG_INTEG_REJECT = 3'd4,
        REG_DRIVE_LIMIT  = 3'd5
    } t_reg_idx;

    // Configuration register file as seen by the datapath.
    typedef struct packed {
        logic signed [15:0] prop_gain;
        logic signed [15:0] integ_gain;
        logic signed [15:0] deriv_gain;
        logic        [15:0] dead_band;
        logic        [14:0] integ_reject;
        logic        [14:0] drive_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        prop_gain:    16'sd0,
        integ_gain:   16'sd0,
        deriv_gain:   16'sd0,
        dead_band:    16'd200,
        integ_reject: 15'd4000,
        drive_limit:  15'd9000
    };

endpackage

// ----- src/positional_pid_deadband_limit.sv -----
// Top level of the positional PID block with error deadband and output clamp.
//
// One item is accepted per clock while the output side is not stalled. Its result
// passes an input register, the integral update, four product, reject, divide and
// clamp-decision stages, and the output register. The integral accumulator and the
// stored error form the only loop, which sets the sustained rate of one item per clock.
// Each pipeline stage holds its item independently, so gaps close up while the output
// waits. Configuration registers are written through a plain indexed write port;
// indexes beyond the list are ignored.
module positional_pid_deadband_limit #(
    parameter int SAMPLE_WIDTH   = pidl_pkg::SAMPLE_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = pidl_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pidl_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [pidl_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_measured,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_target,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pidl_pkg::DRIVE_W-1:0]    o_drive,
    output logic                                   o_limited
);

    localparam int EW = SAMPLE_WIDTH + 1;
    localparam int DW = SAMPLE_WIDTH + 2;
    localparam int IW = INTEGRAL_WIDTH;
    localparam int AW = ((IW > EW) ? IW : EW) + 1;
    localparam int CW = (EW > 16) ? EW : 16;

    pidl_pkg::t_cfg                 r_cfg;
    logic                           r_v1;
    logic signed [SAMPLE_WIDTH-1:0] r_meas;
    logic signed [SAMPLE_WIDTH-1:0] r_tgt;
    logic signed [IW-1:0]           r_integ;
    logic signed [EW-1:0]           r_prev;

    logic                           pipe_rdy;
    logic                           adv1;
    logic signed [EW-1:0]           err;
    logic signed [AW-1:0]           sum_ext;
    logic                           sum_ovf;
    logic signed [IW-1:0]           n_integ;
    logic [EW-1:0]                  abs_err;
    logic                           in_band;
    logic signed [EW-1:0]           n_prev;
    logic signed [DW-1:0]           derr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= pidl_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pidl_pkg::REG_PROP_GAIN:    r_cfg.prop_gain    <= signed'(i_cfg_data);
                pidl_pkg::REG_INTEG_GAIN:   r_cfg.integ_gain   <= signed'(i_cfg_data);
                pidl_pkg::REG_DERIV_GAIN:   r_cfg.deriv_gain   <= signed'(i_cfg_data);
                pidl_pkg::REG_DEAD_BAND:    r_cfg.dead_band    <= i_cfg_data;
                pidl_pkg::REG_INTEG_REJECT: r_cfg.integ_reject <= i_cfg_data[14:0];
                pidl_pkg::REG_DRIVE_LIMIT:  r_cfg.drive_limit  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Input register handshake.
    assign o_in_ready = !r_v1 || pipe_rdy;
    assign adv1       = r_v1 && pipe_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_in_ready) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_meas <= i_measured;
            r_tgt  <= i_target;
        end
    end

    // Error, saturating integral and deadband.
    always_comb begin
        err     = EW'(r_tgt) - EW'(r_meas);
        sum_ext = AW'(r_integ) + AW'(err);
        sum_ovf = !((&sum_ext[AW-1:IW-1]) || !(|sum_ext[AW-1:IW-1]));
        if (sum_ovf) begin
            n_integ = sum_ext[AW-1] ? signed'({1'b1, {(IW-1){1'b0}}})
                                    : signed'({1'b0, {(IW-1){1'b1}}});
        end else begin
            n_integ = sum_ext[IW-1:0];
        end
        abs_err = err[EW-1] ? EW'(-err) : EW'(err);
        in_band = CW'(abs_err) < CW'(r_cfg.dead_band);
        n_prev  = in_band ? '0 : err;
        derr    = DW'(n_prev) - DW'(r_prev);
    end

    // Controller state moves on when the item enters the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (adv1) begin
            r_integ <= n_integ;
            r_prev  <= n_prev;
        end
    end

    pidl_pipe #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (r_v1),
        .o_ready   (pipe_rdy),
        .i_integ   (n_integ),
        .i_err     (n_prev),
        .i_derr    (derr),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_drive   (o_drive),
        .o_limited (o_limited)
    );

    // The controller state only changes when an item moves into the pipeline.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv1 |=> $stable(r_integ) && $stable(r_prev))
        else $error("controller state changed without an item");

    // An error inside the deadband is stored as zero.
    a_band_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && in_band) |=> (r_prev == '0))
        else $error("deadbanded error not stored as zero");

    // Reset clears the controller state.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_integ == '0) && (r_prev == '0) && !r_v1)
        else $error("controller state not cleared by reset");

endmodule

// ----- src/pidl_pipe.sv -----
// Product, divide and clamp pipeline of the positional PID block.
module pidl_pipe #(
    parameter int SAMPLE_WIDTH   = pidl_pkg::SAMPLE_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = pidl_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pidl_pkg::t_cfg                         i_cfg,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [INTEGRAL_WIDTH-1:0]       i_integ,
    input  logic signed [SAMPLE_WIDTH:0]           i_err,
    input  logic signed [SAMPLE_WIDTH+1:0]         i_derr,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [pidl_pkg::DRIVE_W-1:0]    o_drive,
    output logic                                   o_limited
);

    localparam int EW  = SAMPLE_WIDTH + 1;
    localparam int DW  = SAMPLE_WIDTH + 2;
    localparam int PIW = 16 + INTEGRAL_WIDTH;
    localparam int PPW = 16 + EW;
    localparam int PDW = 16 + DW;
    localparam int PSW = PDW + 1;
    localparam int SSW = PSW + 1;
    localparam int IPW = pidl_pkg::DIV_I_XW + pidl_pkg::DIV_I_MW;
    localparam int DPW = pidl_pkg::DIV_D_XW + pidl_pkg::DIV_D_MW;
    localparam int QW  = pidl_pkg::QUOT_W;
    localparam int OW  = pidl_pkg::DRIVE_W;

    // Stage valid flags and load enables.
    logic r_v2, r_v3, r_v4, r_v5, r_v6, r_vo;
    logic ld2, ld3, ld4, ld5, ld6, ldo;

    // Stage payload registers.
    logic signed [INTEGRAL_WIDTH-1:0]    r2_integ;
    logic signed [EW-1:0]                r2_err;
    logic signed [DW-1:0]                r2_derr;
    logic signed [PIW-1:0]               r3_pi;
    logic signed [PPW-1:0]               r3_pp;
    logic signed [PDW-1:0]               r3_pd;
    logic                                r4_ineg;
    logic [pidl_pkg::DIV_I_XW-1:0]       r4_ix;
    logic signed [PSW-1:0]               r4_psum;
    logic signed [OW-1:0]                r5_iterm;
    logic signed [PSW-1:0]               r5_psum;
    logic                                r6_neg;
    logic                                r6_big;
    logic [pidl_pkg::DIV_D_XW-1:0]       r6_dx;
    logic signed [OW-1:0]                r_drive;
    logic                                r_limited;

    // Next values.
    logic signed [PIW-1:0]               n3_pi;
    logic signed [PPW-1:0]               n3_pp;
    logic signed [PDW-1:0]               n3_pd;
    logic [PIW-1:0]                      abs_pi;
    logic [25:0]                         thr_i;
    logic                                rej_i;
    logic                                n4_ineg;
    logic [pidl_pkg::DIV_I_XW-1:0]       n4_ix;
    logic signed [PSW-1:0]               n4_psum;
    logic [IPW-1:0]                      prod_i;
    logic [QW-1:0]                       q_i;
    logic signed [OW-1:0]                iq_s;
    logic signed [OW-1:0]                n5_iterm;
    logic signed [SSW-1:0]               s_iterm_x;
    logic signed [SSW-1:0]               s_total;
    logic [SSW-1:0]                      abs_s;
    logic [22:0]                         thr_d;
    logic                                n6_neg;
    logic                                n6_big;
    logic [pidl_pkg::DIV_D_XW-1:0]       n6_dx;
    logic [DPW-1:0]                      prod_d;
    logic [QW-1:0]                       q_d;
    logic signed [OW-1:0]                dq_s;
    logic signed [OW-1:0]                lim_s;
    logic signed [OW-1:0]                n_drive;

    // A stage loads when it is empty or its contents move on.
    assign ldo     = !r_vo || i_ready;
    assign ld6     = !r_v6 || ldo;
    assign ld5     = !r_v5 || ld6;
    assign ld4     = !r_v4 || ld5;
    assign ld3     = !r_v3 || ld4;
    assign ld2     = !r_v2 || ld3;
    assign o_ready = ld2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (ld2) r_v2 <= i_valid;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
            if (ld5) r_v5 <= r_v4;
            if (ld6) r_v6 <= r_v5;
            if (ldo) r_vo <= r_v6;
        end
    end

    // Stage 3: the three gain products.
    always_comb begin
        n3_pi = PIW'(r2_integ) * PIW'(i_cfg.integ_gain);
        n3_pp = PPW'(r2_err) * PPW'(i_cfg.prop_gain);
        n3_pd = PDW'(r2_derr) * PDW'(i_cfg.deriv_gain);
    end

    // Stage 4: magnitude of the integral product and the reject test. A product
    // at or above 1000*(reject+1) gives a term beyond the reject limit.
    always_comb begin
        abs_pi  = r3_pi[PIW-1] ? PIW'(-r3_pi) : PIW'(r3_pi);
        thr_i   = 26'((26'(i_cfg.integ_reject) + 26'd1) * 26'(pidl_pkg::ITERM_SCALE));
        rej_i   = abs_pi >= PIW'(thr_i);
        n4_ineg = r3_pi[PIW-1];
        n4_ix   = rej_i ? '0 : abs_pi[pidl_pkg::DIV_I_XW-1:0];
        n4_psum = PSW'(r3_pp) + PSW'(r3_pd);
    end

    // Stage 5: divide by 1000 through a reciprocal multiply, sign restored.
    always_comb begin
        prod_i   = IPW'(r4_ix) * IPW'(pidl_pkg::DIV_I_MUL);
        q_i      = prod_i[pidl_pkg::DIV_I_SHIFT +: QW];
        iq_s     = signed'({1'b0, q_i});
        n5_iterm = r4_ineg ? -iq_s : iq_s;
    end

    // Stage 6: full sum before the divide by 100, and the clamp decision. The
    // quotient passes the limit exactly when the sum reaches 100*(limit+1).
    always_comb begin
        s_iterm_x = SSW'(r5_iterm);
        s_total   = SSW'(s_iterm_x * pidl_pkg::DRV_SCALE) + SSW'(r5_psum);
        abs_s     = s_total[SSW-1] ? SSW'(-s_total) : SSW'(s_total);
        thr_d     = 23'((23'(i_cfg.drive_limit) + 23'd1) * 23'(pidl_pkg::DRV_SCALE));
        n6_neg    = s_total[SSW-1];
        n6_big    = abs_s >= SSW'(thr_d);
        n6_dx     = abs_s[pidl_pkg::DIV_D_XW-1:0];
    end

    // Output stage: divide by 100 and apply the clamp.
    always_comb begin
        prod_d = DPW'(r6_dx) * DPW'(pidl_pkg::DIV_D_MUL);
        q_d    = prod_d[pidl_pkg::DIV_D_SHIFT +: QW];
        dq_s   = signed'({1'b0, q_d});
        lim_s  = signed'({1'b0, i_cfg.drive_limit});
        if (r6_big) begin
            n_drive = r6_neg ? -lim_s : lim_s;
        end else begin
            n_drive = r6_neg ? -dq_s : dq_s;
        end
    end

    // Payload registers, loaded with their stage.
    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r2_integ <= i_integ;
            r2_err   <= i_err;
            r2_derr  <= i_derr;
        end
        if (ld3) begin
            r3_pi <= n3_pi;
            r3_pp <= n3_pp;
            r3_pd <= n3_pd;
        end
        if (ld4) begin
            r4_ineg <= n4_ineg;
            r4_ix   <= n4_ix;
            r4_psum <= n4_psum;
        end
        if (ld5) begin
            r5_iterm <= n5_iterm;
            r5_psum  <= r4_psum;
        end
        if (ld6) begin
            r6_neg <= n6_neg;
            r6_big <= n6_big;
            r6_dx  <= n6_dx;
        end
        if (ldo) begin
            r_drive   <= n_drive;
            r_limited <= r6_big;
        end
    end

    assign o_valid   = r_vo;
    assign o_drive   = r_drive;
    assign o_limited = r_limited;

    // The drive never leaves the clamp window.
    a_drive_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_drive <= lim_s) && (o_drive >= -lim_s))
        else $error("drive outside the clamp window");

    // A clamped item sits exactly on one of the limits.
    a_limited_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_limited) |-> ((o_drive == lim_s) || (o_drive == -lim_s)))
        else $error("clamped item not on a limit");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_v2 && !r_v6)
        else $error("pipeline not empty after reset");

endmodule

// ----- tb/sv/pidl_checker.sv -----
// Checker for the positional PID block: tracks both channels, predicts each drive and compares.
module pidl_checker (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_cfg_we,
    input  logic [pidl_pkg::CFG_IDX_W-1:0]                 i_cfg_idx,
    input  logic [pidl_pkg::CFG_DATA_W-1:0]                i_cfg_data,
    input  logic                                           i_in_valid,
    input  logic                                           i_in_ready,
    input  logic signed [pidl_pkg::SAMPLE_WIDTH_DEF-1:0]   i_measured,
    input  logic signed [pidl_pkg::SAMPLE_WIDTH_DEF-1:0]   i_target,
    input  logic                                           i_out_valid,
    input  logic                                           i_out_ready,
    input  logic signed [pidl_pkg::DRIVE_W-1:0]            i_drive,
    input  logic                                           i_limited,
    output int                                             o_fail_count,
    output int                                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Bounds of the saturating integral accumulator.
    localparam longint INTEG_MAX = 64'sd2147483647;
    localparam longint INTEG_MIN = -INTEG_MAX - 64'sd1;

    typedef struct packed {
        logic signed [pidl_pkg::DRIVE_W-1:0] drive;
        logic                                limited;
    } t_drive_result;

    // Private copy of the register file and of the controller state.
    pidl_pkg::t_cfg                                 gains;
    logic signed [pidl_pkg::INTEGRAL_WIDTH_DEF-1:0] integ_acc;
    logic signed [pidl_pkg::SAMPLE_WIDTH_DEF:0]     last_err;
    t_drive_result                                  drives_due[$];
    int                                             fails = 0;

    // One controller step: updates the integral and the stored error, returns the drive.
    function automatic t_drive_result predict_drive(
        input logic signed [pidl_pkg::SAMPLE_WIDTH_DEF-1:0] meas,
        input logic signed [pidl_pkg::SAMPLE_WIDTH_DEF-1:0] tgt);
        longint        err, acc, iterm, raw;
        longint        kp, ki, kd, band, reject, limit;
        t_drive_result r;
        kp     = longint'(gains.prop_gain);
        ki     = longint'(gains.integ_gain);
        kd     = longint'(gains.deriv_gain);
        band   = longint'(gains.dead_band);
        reject = longint'(gains.integ_reject);
        limit  = longint'(gains.drive_limit);

        // The raw error feeds the integral before the deadband is applied.
        err = longint'(tgt) - longint'(meas);
        acc = longint'(integ_acc) + err;
        if (acc > INTEG_MAX) begin
            acc = INTEG_MAX;
        end else if (acc < INTEG_MIN) begin
            acc = INTEG_MIN;
        end
        integ_acc = pidl_pkg::INTEGRAL_WIDTH_DEF'(acc);

        if (err < band && err > -band) begin
            err = 0;
        end

        // Integral term, thrown away when it grows beyond the reject level.
        iterm = (ki * acc) / longint'(pidl_pkg::ITERM_SCALE);
        if (iterm > reject || iterm < -reject) begin
            iterm = 0;
        end

        raw = (longint'(pidl_pkg::DRV_SCALE) * iterm + kp * err
               + kd * (err - longint'(last_err))) / longint'(pidl_pkg::DRV_SCALE);
        last_err = (pidl_pkg::SAMPLE_WIDTH_DEF + 1)'(err);

        // Symmetric clamp; a drive exactly on the limit is not flagged.
        r.limited = 1'b0;
        if (raw > limit) begin
            r.drive   = pidl_pkg::DRIVE_W'(limit);
            r.limited = 1'b1;
        end else if (raw < -limit) begin
            r.drive   = pidl_pkg::DRIVE_W'(-limit);
            r.limited = 1'b1;
        end else begin
            r.drive = pidl_pkg::DRIVE_W'(raw);
        end
        return r;
    endfunction

    task automatic note_failure(input string what, input longint want, input longint got);
        fails++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Register writes, accepted items and delivered results, all seen at the clock edge.
    always @(posedge i_clk) begin
        t_drive_result want;
        if (!i_rst_n) begin
            gains     = pidl_pkg::CFG_RESET;
            integ_acc = '0;
            last_err  = '0;
            drives_due.delete();
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pidl_pkg::REG_PROP_GAIN:    gains.prop_gain    = i_cfg_data;
                    pidl_pkg::REG_INTEG_GAIN:   gains.integ_gain   = i_cfg_data;
                    pidl_pkg::REG_DERIV_GAIN:   gains.deriv_gain   = i_cfg_data;
                    pidl_pkg::REG_DEAD_BAND:    gains.dead_band    = i_cfg_data;
                    pidl_pkg::REG_INTEG_REJECT: gains.integ_reject = i_cfg_data[14:0];
                    pidl_pkg::REG_DRIVE_LIMIT:  gains.drive_limit  = i_cfg_data[14:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                drives_due.push_back(predict_drive(i_measured, i_target));
            end

            if (i_out_valid && i_out_ready) begin
                if (drives_due.size() == 0) begin
                    fails++;
                    $display("%0t: item mismatch: expected no item, got drive %0d limited %0d",
                             $time, i_drive, i_limited);
                end else begin
                    want = drives_due.pop_front();
                    if (want.drive !== i_drive) begin
                        note_failure("drive", longint'(want.drive), longint'(i_drive));
                    end
                    if (want.limited !== i_limited) begin
                        note_failure("limited", longint'(want.limited), longint'(i_limited));
                    end
                end
            end
        end
        o_pending    <= drives_due.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the PID block testbench: clock, reset, stimulus, output pacing and the verdict.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W        = pidl_pkg::SAMPLE_WIDTH_DEF;
    localparam int RESET_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 20;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int SEG_COUNT       = 7;
    localparam int SEG_ITEMS       = 185;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [pidl_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [pidl_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_cfg_we    = 1'b0;
    logic [pidl_pkg::CFG_IDX_W-1:0]      i_cfg_idx   = '0;
    logic [pidl_pkg::CFG_DATA_W-1:0]     i_cfg_data  = '0;
    logic                                i_in_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0]          i_measured  = '0;
    logic signed [SAMPLE_W-1:0]          i_target    = '0;
    logic                                i_out_ready = 1'b0;
    logic                                o_in_ready;
    logic                                o_out_valid;
    logic signed [pidl_pkg::DRIVE_W-1:0] o_drive;
    logic                                o_limited;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Pacing flags shared by the sending and the receiving side.
    bit calm         = 1'b0;
    bit hold_off_req = 1'b0;
    bit holding      = 1'b0;

    positional_pid_deadband_limit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_measured  (i_measured),
        .i_target    (i_target),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive),
        .o_limited   (o_limited)
    );

    pidl_checker pid_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_measured   (i_measured),
        .i_target     (i_target),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_drive      (o_drive),
        .i_limited    (o_limited),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Gap before the next item: mostly none, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (calm || holding || hold_off_req) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic signed [15:0] draw_gain();
        case ($urandom_range(0, 2))
            0:       return 16'(int'($urandom_range(0, 600)) - 300);
            1:       return 16'(int'($urandom_range(0, 6000)) - 3000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return 16'sh7fff;
        endcase
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_sample(input logic signed [15:0] meas, input logic signed [15:0] tgt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_measured <= meas;
        i_target   <= tgt;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Write the whole register file, plus both spare indexes with junk data.
    task automatic apply_cfg(input pidl_pkg::t_cfg c);
        logic [pidl_pkg::CFG_IDX_W-1:0]  idx [8];
        logic [pidl_pkg::CFG_DATA_W-1:0] val [8];
        idx = '{CFG_IDX_SPARE_LO, pidl_pkg::REG_PROP_GAIN, pidl_pkg::REG_INTEG_GAIN,
                pidl_pkg::REG_DERIV_GAIN, pidl_pkg::REG_DEAD_BAND,
                pidl_pkg::REG_INTEG_REJECT, pidl_pkg::REG_DRIVE_LIMIT, CFG_IDX_SPARE_HI};
        val = '{16'($urandom), c.prop_gain, c.integ_gain, c.deriv_gain, c.dead_band,
                {1'($urandom), c.integ_reject}, {1'($urandom), c.drive_limit},
                16'($urandom)};
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Random items: wide jumps, near-setpoint errors around the deadband, extremes,
    // and small signals between -1000 and 1000.
    task automatic run_random(input int count);
        int                  r, m, t;
        logic signed [15:0]  meas, tgt;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                calm = ($urandom_range(0, 4) == 0);
            end
            r = $urandom_range(0, 19);
            if (r < 6) begin
                meas = 16'($urandom);
                tgt  = 16'($urandom);
            end else if (r < 14) begin
                m = int'($signed(16'($urandom)));
                t = m + int'($urandom_range(0, 1200)) - 600;
                if (t > 32767) t = 32767;
                if (t < -32768) t = -32768;
                meas = 16'(m);
                tgt  = 16'(t);
            end else if (r < 17) begin
                meas = pick_extreme();
                tgt  = pick_extreme();
            end else begin
                meas = 16'(int'($urandom_range(0, 2000)) - 1000);
                tgt  = 16'(int'($urandom_range(0, 2000)) - 1000);
            end
            send_sample(meas, tgt);
        end
        calm = 1'b0;
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off on request.
    initial begin
        int r;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                holding      = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                holding = 1'b0;
            end else if (calm) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end else if (r < 92) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(8, 40)) @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        pidl_pkg::t_cfg c;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: all gains are zero, so the drive must stay at zero.
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sd0, 16'sd0);
        settle();

        // Unity proportional gain: deadband edges, drive on and just past the clamp.
        c = pidl_pkg::CFG_RESET;
        c.prop_gain = 16'sd100;
        apply_cfg(c);
        send_sample(16'sd0, 16'sd199);
        send_sample(16'sd0, -16'sd199);
        send_sample(16'sd0, 16'sd200);
        send_sample(16'sd0, -16'sd200);
        send_sample(16'sd0, 16'sd9000);
        send_sample(16'sd0, 16'sd9001);
        send_sample(16'sd0, -16'sd9000);
        send_sample(16'sd0, -16'sd9001);
        send_sample(16'sh8000, 16'sh7fff);
        settle();

        // Extreme gains with no deadband and a zero clamp: drive held at zero,
        // flagged whenever the unclamped value is not zero.
        c.prop_gain    = 16'sh8000;
        c.integ_gain   = 16'sh7fff;
        c.deriv_gain   = 16'sh7fff;
        c.dead_band    = 16'd0;
        c.integ_reject = 15'h7fff;
        c.drive_limit  = 15'd0;
        apply_cfg(c);
        send_sample(16'sd0, 16'sd1);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        settle();

        // Integral term around a tiny reject level: kept at the level, dropped above it.
        c.prop_gain    = 16'sd0;
        c.integ_gain   = 16'sd1000;
        c.deriv_gain   = 16'sd100;
        c.integ_reject = 15'd5;
        c.drive_limit  = 15'h7fff;
        apply_cfg(c);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sd0, 16'sd3);
        send_sample(16'sd0, 16'sd3);
        send_sample(16'sd0, -16'sd1);
        settle();

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            if (seg == 0) begin
                // Largest gains, widest deadband, widest reject and clamp.
                c.prop_gain    = 16'sh7fff;
                c.integ_gain   = 16'sh7fff;
                c.deriv_gain   = 16'sh7fff;
                c.dead_band    = 16'hffff;
                c.integ_reject = 15'h7fff;
                c.drive_limit  = 15'h7fff;
            end else if (seg == 1) begin
                // Most negative gains, no deadband, integral term always rejected.
                c.prop_gain    = 16'sh8000;
                c.integ_gain   = 16'sh8000;
                c.deriv_gain   = 16'sh8000;
                c.dead_band    = 16'd0;
                c.integ_reject = 15'd0;
                c.drive_limit  = 15'h7fff;
            end else begin
                c.prop_gain  = draw_gain();
                c.integ_gain = draw_gain();
                c.deriv_gain = draw_gain();
                case ($urandom_range(0, 3))
                    0:       c.dead_band = 16'd0;
                    1, 2:    c.dead_band = 16'($urandom_range(0, 400));
                    default: c.dead_band = 16'($urandom);
                endcase
                c.integ_reject = $urandom_range(0, 1) ? 15'($urandom)
                                                      : 15'($urandom_range(0, 2000));
                c.drive_limit  = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 500))
                                                             : 15'($urandom);
            end

            apply_cfg(c);
            // Starve the output for a long stretch so the block fills and backs up.
            if (seg == 1) begin
                hold_off_req = 1'b1;
            end
            run_random(SEG_ITEMS);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
